// ----- design/hpm_pkg.sv -----
// ----------------------------------------------------------------------------
// hpm_pkg: shared types and codes for the HARQ transmit process manager
// Request and event codes, register indexes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hpm_pkg;

   // Request codes
   localparam logic [2:0] REQ_SEND  = 3'd0;
   localparam logic [2:0] REQ_ACK   = 3'd1;
   localparam logic [2:0] REQ_NACK  = 3'd2;
   localparam logic [2:0] REQ_TICK  = 3'd3;
   localparam logic [2:0] REQ_CLEAR = 3'd4;

   // Event codes
   localparam logic [1:0] EV_NEW_TX   = 2'd0;
   localparam logic [1:0] EV_RETX     = 2'd1;
   localparam logic [1:0] EV_DROPPED  = 2'd2;
   localparam logic [1:0] EV_REJECTED = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_PROCS_IN_USE = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT  = 2'd1;
   localparam logic [1:0] CSR_RETRY_LIMIT  = 2'd2;

   // Entry store layout: retry count above the deadline
   localparam int RC_W    = 8;
   localparam int TIME_W  = 32;
   localparam int ENTRY_W = RC_W + TIME_W;

   typedef struct packed {
      logic [1:0]      kind;
      logic [5:0]      proc_num;
      logic            ndi;
      logic [RC_W-1:0] attempt;
   } result_type;

   typedef struct packed {
      logic load;       // latch the accepted request
      logic idx_start;  // index from the search pointer, count cleared
      logic idx_zero;   // index zero, count cleared
      logic idx_pid;    // index from the request's process id, count cleared
      logic idx_norm;   // index reduced by the active count
      logic idx_step;   // index advanced with wrap, count incremented
      logic take;       // claim the entry at the index for a new transmission
      logic reject;     // stage a rejected result
      logic ack;        // free the process named by the request
      logic clear;      // free every process
      logic tmark;      // raise the time mark
      logic rd;         // read the entry store at the index
      logic retry;      // retransmit or drop the entry at the index
      logic flush;      // send the staged result as the final one
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       pid_ok;
      logic       idx_ge_n;
      logic       idx_busy;
      logic       scan_done;
      logic       hit;
      logic       pend_valid;
      logic       can_push;
   } status_type;

endpackage

// ----- design/hpm_ram.sv -----
// ----------------------------------------------------------------------------
// hpm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hpm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/hpm_datapath.sv -----
// ----------------------------------------------------------------------------
// hpm_datapath: process table, registers and result path
// Holds the busy, new-data and retry-count valid flags, the entry store for
// retry counts and deadlines, the staged result and the output register.
// ----------------------------------------------------------------------------
module hpm_datapath #(
   parameter int NUM_PROC = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_type,
   input  logic [6:0]           req_proc_id,
   input  logic [31:0]          req_now_ms,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  hpm_pkg::cmd_type     cmd,
   output hpm_pkg::status_type  status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_event_kind,
   output logic [5:0]           rsp_proc_out,
   output logic                 rsp_new_data_bit,
   output logic [7:0]           rsp_attempt,
   output logic                 rsp_last
);

   localparam int IW = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
   localparam logic [6:0] NumProc = 7'(NUM_PROC);

   // Configuration
   logic [6:0]  piu_ff;
   logic [31:0] ack_to_ff;
   logic [7:0]  limit_ff;

   // Latched request
   logic [2:0]  kind_ff;
   logic [6:0]  pid_ff;
   logic [31:0] now_ff;

   // Scan state
   logic [IW-1:0] idx_ff;
   logic [6:0]    cnt_ff;
   logic [IW-1:0] ss_ff;
   logic [31:0]   tmark_ff;

   // Per-process flags
   logic [NUM_PROC-1:0] busy_ff, busy_in;
   logic [NUM_PROC-1:0] ndi_ff, ndi_in;
   logic [NUM_PROC-1:0] rcv_ff, rcv_in;

   // Staged result and output register
   logic                 pend_valid_ff;
   hpm_pkg::result_type  pend_ff;
   logic                 rsp_valid_ff;
   hpm_pkg::result_type  rsp_ff;
   logic                 rsp_last_ff;

   logic [6:0]  n_act;
   logic [6:0]  idx_ext;
   logic [6:0]  idx_red;
   logic [IW-1:0] idx_wrap_next;
   logic [31:0] deadline_new;
   logic [hpm_pkg::ENTRY_W-1:0] ram_rd_data;
   logic [hpm_pkg::ENTRY_W-1:0] ram_wr_data;
   logic        ram_wr_en;
   logic [7:0]  rc_rd;
   logic [7:0]  rc_inc;
   logic [31:0] diff;
   logic        drop;
   logic        pid_ok;
   logic        can_push;
   logic        push;
   hpm_pkg::result_type retry_res;
   hpm_pkg::result_type take_res;
   hpm_pkg::result_type rej_res;

   // A count of zero acts as one; counts above the built size are capped.
   always_comb begin
      if (piu_ff == 7'd0) begin
         n_act = 7'd1;
      end else if (piu_ff > NumProc) begin
         n_act = NumProc;
      end else begin
         n_act = piu_ff;
      end
   end

   assign idx_ext       = 7'(idx_ff);
   assign idx_red       = idx_ext - n_act;
   assign idx_wrap_next = ((idx_ext + 7'd1) == n_act) ? '0 : idx_ff + IW'(1);
   assign deadline_new  = tmark_ff + ack_to_ff;
   assign pid_ok        = pid_ff < n_act;

   // A retry count whose entry was cleared reads as zero.
   assign rc_rd  = rcv_ff[idx_ff] ? ram_rd_data[hpm_pkg::ENTRY_W-1:hpm_pkg::TIME_W] : 8'd0;
   assign rc_inc = rc_rd + 8'd1;
   assign diff   = now_ff - ram_rd_data[hpm_pkg::TIME_W-1:0];
   assign drop   = rc_rd >= limit_ff;

   always_comb begin
      retry_res.kind     = drop ? hpm_pkg::EV_DROPPED : hpm_pkg::EV_RETX;
      retry_res.proc_num = 6'(idx_ff);
      retry_res.ndi      = ndi_ff[idx_ff];
      retry_res.attempt  = drop ? rc_rd : rc_inc;
      take_res.kind      = hpm_pkg::EV_NEW_TX;
      take_res.proc_num  = 6'(idx_ff);
      take_res.ndi       = ~ndi_ff[idx_ff];
      take_res.attempt   = 8'd0;
      rej_res.kind       = hpm_pkg::EV_REJECTED;
      rej_res.proc_num   = 6'd0;
      rej_res.ndi        = 1'b0;
      rej_res.attempt    = 8'd0;
   end

   assign ram_wr_en   = cmd.take | (cmd.retry & ~drop);
   assign ram_wr_data = {(cmd.take ? 8'd0 : rc_inc), deadline_new};

   hpm_ram #(
      .WIDTH (hpm_pkg::ENTRY_W),
      .DEPTH (NUM_PROC)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      busy_in = busy_ff;
      ndi_in  = ndi_ff;
      rcv_in  = rcv_ff;
      if (cmd.take) begin
         busy_in[idx_ff] = 1'b1;
         ndi_in[idx_ff]  = ~ndi_ff[idx_ff];
         rcv_in[idx_ff]  = 1'b1;
      end
      if (cmd.retry) begin
         if (drop) begin
            busy_in[idx_ff] = 1'b0;
         end else begin
            rcv_in[idx_ff] = 1'b1;
         end
      end
      if (cmd.ack && pid_ok) begin
         busy_in[pid_ff[IW-1:0]] = 1'b0;
      end
      if (cmd.clear) begin
         busy_in = '0;
         rcv_in  = '0;
      end
   end

   assign can_push = ~rsp_valid_ff | rsp_ready;
   // A new tick hit pushes the previous one out; the final one leaves on flush.
   assign push     = (cmd.retry & pend_valid_ff) | cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         piu_ff        <= 7'd8;
         ack_to_ff     <= 32'd10;
         limit_ff      <= 8'd4;
         busy_ff       <= '0;
         ndi_ff        <= '0;
         rcv_ff        <= '0;
         ss_ff         <= '0;
         tmark_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               hpm_pkg::CSR_PROCS_IN_USE: piu_ff    <= csr_wdata[6:0];
               hpm_pkg::CSR_ACK_TIMEOUT:  ack_to_ff <= csr_wdata;
               hpm_pkg::CSR_RETRY_LIMIT:  limit_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
         busy_ff <= busy_in;
         ndi_ff  <= ndi_in;
         rcv_ff  <= rcv_in;
         if (cmd.clear) begin
            ss_ff <= '0;
         end else if (cmd.take) begin
            ss_ff <= idx_wrap_next;
         end
         if (cmd.tmark && (now_ff > tmark_ff)) begin
            tmark_ff <= now_ff;
         end
         if (cmd.take || cmd.reject || cmd.retry) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_type;
         pid_ff  <= req_proc_id;
         now_ff  <= req_now_ms;
      end
      if (cmd.idx_start) begin
         idx_ff <= ss_ff;
         cnt_ff <= 7'd0;
      end else if (cmd.idx_zero) begin
         idx_ff <= '0;
         cnt_ff <= 7'd0;
      end else if (cmd.idx_pid) begin
         idx_ff <= pid_ff[IW-1:0];
         cnt_ff <= 7'd0;
      end else if (cmd.idx_norm) begin
         idx_ff <= idx_red[IW-1:0];
      end else if (cmd.idx_step) begin
         idx_ff <= idx_wrap_next;
         cnt_ff <= cnt_ff + 7'd1;
      end
      if (cmd.take) begin
         pend_ff <= take_res;
      end else if (cmd.reject) begin
         pend_ff <= rej_res;
      end else if (cmd.retry) begin
         pend_ff <= retry_res;
      end
      if (push) begin
         rsp_ff      <= pend_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   always_comb begin
      status.kind       = kind_ff;
      status.pid_ok     = pid_ok;
      status.idx_ge_n   = idx_ext >= n_act;
      status.idx_busy   = busy_ff[idx_ff];
      status.scan_done  = cnt_ff == (n_act - 7'd1);
      status.hit        = ~diff[31];
      status.pend_valid = pend_valid_ff;
      status.can_push   = can_push;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_ff.kind;
   assign rsp_proc_out     = rsp_ff.proc_num;
   assign rsp_new_data_bit = rsp_ff.ndi;
   assign rsp_attempt      = rsp_ff.attempt;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- design/hpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// hpm_ctrl: request sequencer
// Decodes each item and walks the process table one entry at a time,
// issuing commands to the datapath.
// ----------------------------------------------------------------------------
module hpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output hpm_pkg::cmd_type    cmd,
   input  hpm_pkg::status_type status
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_NORM     = 4'd2;
   localparam logic [3:0] ST_SEND     = 4'd3;
   localparam logic [3:0] ST_NACK_CHK = 4'd4;
   localparam logic [3:0] ST_NACK_EV  = 4'd5;
   localparam logic [3:0] ST_TICK_RD  = 4'd6;
   localparam logic [3:0] ST_TICK_EV  = 4'd7;
   localparam logic [3:0] ST_FLUSH    = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.kind)
               hpm_pkg::REQ_SEND: begin
                  cmd.idx_start = 1'b1;
                  state_in      = ST_NORM;
               end
               hpm_pkg::REQ_ACK: begin
                  cmd.ack  = 1'b1;
                  state_in = ST_IDLE;
               end
               hpm_pkg::REQ_NACK: begin
                  if (status.pid_ok) begin
                     cmd.idx_pid = 1'b1;
                     state_in    = ST_NACK_CHK;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               hpm_pkg::REQ_TICK: begin
                  cmd.tmark    = 1'b1;
                  cmd.idx_zero = 1'b1;
                  state_in     = ST_TICK_RD;
               end
               hpm_pkg::REQ_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_NORM: begin
            // The pointer can sit past the active count after a resize.
            if (status.idx_ge_n) begin
               cmd.idx_norm = 1'b1;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!status.idx_busy) begin
               cmd.take = 1'b1;
               state_in = ST_FLUSH;
            end else if (status.scan_done) begin
               cmd.reject = 1'b1;
               state_in   = ST_FLUSH;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         ST_NACK_CHK: begin
            if (status.idx_busy) begin
               cmd.rd   = 1'b1;
               state_in = ST_NACK_EV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NACK_EV: begin
            cmd.retry = 1'b1;
            state_in  = ST_FLUSH;
         end
         ST_TICK_RD: begin
            if (status.idx_busy) begin
               cmd.rd   = 1'b1;
               state_in = ST_TICK_EV;
            end else if (status.scan_done) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         ST_TICK_EV: begin
            // A hit waits while the previously staged result cannot move out.
            if (!status.hit || !status.pend_valid || status.can_push) begin
               cmd.retry = status.hit;
               if (status.scan_done) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = ST_TICK_RD;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.can_push) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

// ----- design/harq_tx_process_manager_core.sv -----
// ----------------------------------------------------------------------------
// harq_tx_process_manager_core: HARQ transmit process manager
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_type, req_proc_id, req_now_ms
// rsp       out        rsp_valid, rsp_ready, rsp_event_kind, rsp_proc_out,
//                      rsp_new_data_bit, rsp_attempt, rsp_last
// csr       in         csr_we, csr_index, csr_wdata
//
// One item is worked at a time. Ack, clear and ignored items pass only through
// dispatch; a nack in range checks the busy flag, and for a busy process reads
// the entry store, then retries or drops. A send brings a pointer left past n by
// a resize below n, then scans at most n active processes. A tick scans all n
// active entries; each busy one's retry count and deadline are read and evaluated.
// Reset clears the tables at once; there is no clearing pass. A stalled result
// output holds up a tick or the end of an item only once the staged result
// and the output register are both full.
// ----------------------------------------------------------------------------
module harq_tx_process_manager_core #(
   parameter int NUM_PROC = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [6:0]  req_proc_id,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [5:0]  rsp_proc_out,
   output logic        rsp_new_data_bit,
   output logic [7:0]  rsp_attempt,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   hpm_pkg::cmd_type    dp_cmd;
   hpm_pkg::status_type dp_status;

   hpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   hpm_datapath #(
      .NUM_PROC (NUM_PROC)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_proc_id      (req_proc_id),
      .req_now_ms       (req_now_ms),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_proc_out     (rsp_proc_out),
      .rsp_new_data_bit (rsp_new_data_bit),
      .rsp_attempt      (rsp_attempt),
      .rsp_last         (rsp_last)
   );

   // No staged result may be left behind when a new item can be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !dp_status.pend_valid)
      else $error("staged result left over while idle");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken before the first was worked");

   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.take |-> !dp_status.idx_busy)
      else $error("busy process claimed by a send");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == hpm_pkg::EV_REJECTED ||
                     rsp_event_kind == hpm_pkg::EV_NEW_TX))
      |-> (rsp_last && rsp_attempt == 8'd0))
      else $error("send result not final or with nonzero attempt");

endmodule

// ----- dv/harq_tx_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harq_tx_event_checker: event scoreboard for the HARQ transmit process manager
// Keeps a shadow copy of the process table and registers, updated from every
// accepted request item and register write. It queues the events each request
// should raise and compares each event item the block hands over, field by
// field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module harq_tx_event_checker #(
   parameter int NUM_PROC = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [6:0]  req_proc_id,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_event_kind,
   input  logic [5:0]  rsp_proc_out,
   input  logic        rsp_new_data_bit,
   input  logic [7:0]  rsp_attempt,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          resend_count,
   output int          drop_count
);

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] proc_num;
      logic       ndi;
      logic [7:0] attempt;
      logic       last;
   } tx_event_type;

   logic [6:0]  procs_reg;
   logic [31:0] timeout_reg;
   logic [7:0]  limit_reg;

   logic        busy_q  [NUM_PROC];
   logic        ndi_q   [NUM_PROC];
   logic [7:0]  tries_q [NUM_PROC];
   logic [31:0] due_q   [NUM_PROC];
   int unsigned search_ptr;
   logic [31:0] mark_ms;

   tx_event_type expected_events[$];
   tx_event_type burst[$];

   function automatic int unsigned live_count();
      if (procs_reg == 7'd0) return 1;
      if (procs_reg > NUM_PROC) return NUM_PROC;
      return int'(procs_reg);
   endfunction

   // New-data bits and deadlines survive a clear; only power-on wipes them.
   task automatic free_all(input bit power_on);
      int unsigned p;
      for (p = 0; p < NUM_PROC; p++) begin
         busy_q[p] = 1'b0;
         tries_q[p] = 8'd0;
         if (power_on) begin
            ndi_q[p] = 1'b0;
            due_q[p] = 32'd0;
         end
      end
      search_ptr = 0;
   endtask

   task automatic retry_or_drop(input int unsigned p);
      tx_event_type ev;
      ev.proc_num = p[5:0];
      ev.ndi = ndi_q[p];
      ev.last = 1'b0;
      if (tries_q[p] >= limit_reg) begin
         busy_q[p] = 1'b0;
         ev.kind = hpm_pkg::EV_DROPPED;
      end else begin
         tries_q[p] = tries_q[p] + 8'd1;
         due_q[p] = mark_ms + timeout_reg;
         ev.kind = hpm_pkg::EV_RETX;
      end
      ev.attempt = tries_q[p];
      burst = {burst, ev};
   endtask

   task automatic predict_request(input logic [2:0] op, input logic [6:0] pid,
                                  input logic [31:0] now);
      int unsigned  n;
      int unsigned  i;
      int unsigned  p;
      logic [31:0]  lag;
      bit           taken;
      tx_event_type ev;
      n = live_count();
      taken = 1'b0;
      burst.delete();
      case (op)
         hpm_pkg::REQ_SEND: begin
            for (i = 0; i < n; i++) begin
               p = (search_ptr + i) % n;
               if (!taken && !busy_q[p]) begin
                  taken = 1'b1;
                  busy_q[p] = 1'b1;
                  ndi_q[p] = ~ndi_q[p];
                  tries_q[p] = 8'd0;
                  due_q[p] = mark_ms + timeout_reg;
                  search_ptr = (p + 1) % n;
                  ev.kind = hpm_pkg::EV_NEW_TX;
                  ev.proc_num = p[5:0];
                  ev.ndi = ndi_q[p];
                  ev.attempt = 8'd0;
                  ev.last = 1'b0;
                  burst = {burst, ev};
               end
            end
            if (!taken) begin
               ev = '0;
               ev.kind = hpm_pkg::EV_REJECTED;
               burst = {burst, ev};
            end
         end
         hpm_pkg::REQ_ACK: begin
            if (pid < n) busy_q[pid] = 1'b0;
         end
         hpm_pkg::REQ_NACK: begin
            if (pid < n) begin
               if (busy_q[pid]) retry_or_drop(int'(pid));
            end
         end
         hpm_pkg::REQ_TICK: begin
            if (now > mark_ms) mark_ms = now;
            // A deadline counts as passed when now - deadline is not negative
            // as a signed 32-bit value, which stays correct across the wrap.
            for (p = 0; p < n; p++) begin
               if (busy_q[p]) begin
                  lag = now - due_q[p];
                  if (!lag[31]) retry_or_drop(p);
               end
            end
         end
         hpm_pkg::REQ_CLEAR: free_all(1'b0);
         default: ;
      endcase
      if (burst.size() > 0) begin
         burst[burst.size() - 1].last = 1'b1;
      end
      expected_events = {expected_events, burst};
   endtask

   function automatic int field_mismatch(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic check_event();
      tx_event_type want;
      if (expected_events.size() == 0) begin
         $error("unexpected event item: kind %0d, process %0d", rsp_event_kind,
                rsp_proc_out);
         fail_count++;
      end else begin
         want = expected_events.pop_front();
         fail_count += field_mismatch("event_kind", want.kind, rsp_event_kind)
                     + field_mismatch("proc_out", want.proc_num, rsp_proc_out)
                     + field_mismatch("new_data_bit", want.ndi, rsp_new_data_bit)
                     + field_mismatch("attempt", want.attempt, rsp_attempt)
                     + field_mismatch("last", want.last, rsp_last);
         checked_count++;
         if (want.kind == hpm_pkg::EV_RETX) resend_count++;
         if (want.kind == hpm_pkg::EV_DROPPED) drop_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         procs_reg = 7'd8;
         timeout_reg = 32'd10;
         limit_reg = 8'd4;
         free_all(1'b1);
         mark_ms = 32'd0;
         expected_events.delete();
         fail_count = 0;
         checked_count = 0;
         resend_count = 0;
         drop_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_event();
         if (csr_we) begin
            case (csr_index)
               hpm_pkg::CSR_PROCS_IN_USE: procs_reg = csr_wdata[6:0];
               hpm_pkg::CSR_ACK_TIMEOUT:  timeout_reg = csr_wdata;
               hpm_pkg::CSR_RETRY_LIMIT:  limit_reg = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_request(req_type, req_proc_id, req_now_ms);
      end
      pending_count = expected_events.size();
   end

endmodule

// ----- dv/tb_harq_tx_process_manager_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_harq_tx_process_manager_core: testbench for the HARQ transmit manager
// A directed opening walks full and empty tables, ignored acks and nacks,
// exact deadline hits, a drop and a clear. Random traffic then runs under a
// series of register settings, with random gaps and stalls on both channels,
// a long output stall and a time wrap. A separate checker scores the events.
// ----------------------------------------------------------------------------
module tb_harq_tx_process_manager_core;

   localparam int NUM_PROC          = 8;
   localparam int CLK_PERIOD        = 8;
   localparam int SETTLE_CYCLES     = 2 * NUM_PROC + 8;
   localparam int HOLD_CYCLES       = 300;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int NUM_SETTINGS      = 7;
   localparam int ITEMS_PER_SETTING = 55;
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [6:0]  req_proc_id;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_event_kind;
   logic [5:0]  rsp_proc_out;
   logic        rsp_new_data_bit;
   logic [7:0]  rsp_attempt;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   int fail_count;
   int pending_count;
   int checked_count;
   int resend_count;
   int drop_count;
   int cycle_count;
   int issued;
   int live_cnt;
   logic [31:0] wall_ms;
   bit quiet_tx;
   bit quiet_rx;
   bit hold_req;

   harq_tx_process_manager_core #(.NUM_PROC(NUM_PROC)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_proc_id      (req_proc_id),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_proc_out     (rsp_proc_out),
      .rsp_new_data_bit (rsp_new_data_bit),
      .rsp_attempt      (rsp_attempt),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   harq_tx_event_checker #(.NUM_PROC(NUM_PROC)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_proc_id      (req_proc_id),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_proc_out     (rsp_proc_out),
      .rsp_new_data_bit (rsp_new_data_bit),
      .rsp_attempt      (rsp_attempt),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .resend_count     (resend_count),
      .drop_count       (drop_count)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_harq_tx_process_manager_core: FAIL");
         $finish;
      end
   end

   // Valid is lowered only when a gap is drawn, so back-to-back items keep it
   // high without a drop and rise in the same time step.
   task automatic push_req(input logic [2:0] op, input logic [6:0] pid,
                           input logic [31:0] ms);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_proc_id <= pid;
      req_now_ms <= ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      issued++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      // Items without events may still be in flight inside the block.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_setting(input int k);
      logic [6:0]  procs;
      logic [31:0] tmo;
      logic [7:0]  lim;
      case (k)
         1: begin procs = 7'd1;   tmo = 32'd0;          lim = 8'd0;   end
         2: begin procs = 7'd64;  tmo = 32'hFFFF_FFFF;  lim = 8'd255; end
         3: begin procs = 7'd0;   tmo = 32'd5;          lim = 8'd1;   end
         4: begin procs = 7'd5;   tmo = 32'd3;          lim = 8'd2;   end
         5: begin procs = 7'd127; tmo = 32'h8000_0000;  lim = 8'd3;   end
         default: begin procs = 7'd3; tmo = 32'h7FFF_FFFF; lim = 8'd0; end
      endcase
      write_reg(hpm_pkg::CSR_PROCS_IN_USE, {25'd0, procs});
      write_reg(hpm_pkg::CSR_ACK_TIMEOUT, tmo);
      write_reg(hpm_pkg::CSR_RETRY_LIMIT, {24'd0, lim});
      csr_we <= 1'b0;
      @(negedge clock);
      live_cnt = (procs == 7'd0) ? 1 : (procs > NUM_PROC) ? NUM_PROC : procs;
   endtask

   // Time mostly creeps forward; some ticks look back, and in the wrap phase
   // some carry an arbitrary time.
   function automatic logic [31:0] tick_time(input bit wild);
      int sel;
      sel = $urandom_range(0, 9);
      if (wild && sel == 0) return $urandom;
      if (sel == 1) return wall_ms - $urandom_range(1, 12);
      wall_ms = wall_ms + $urandom_range(0, 6);
      return wall_ms;
   endfunction

   task automatic random_item(input bit wild, output bit counts);
      int          sel;
      logic [2:0]  op;
      logic [6:0]  pid;
      logic [31:0] ms;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) pid = 7'($urandom_range(0, 127));
      else pid = 7'($urandom_range(0, live_cnt - 1));
      ms = $urandom;
      if (sel < 35) op = hpm_pkg::REQ_SEND;
      else if (sel < 55) op = hpm_pkg::REQ_ACK;
      else if (sel < 75) op = hpm_pkg::REQ_NACK;
      else if (sel < 95) op = hpm_pkg::REQ_TICK;
      else if (sel < 98) op = hpm_pkg::REQ_CLEAR;
      else op = REQ_UNUSED_LO + 3'($urandom_range(0, 2));
      if (op == hpm_pkg::REQ_TICK) ms = tick_time(wild);
      push_req(op, pid, ms);
      counts = (op <= hpm_pkg::REQ_CLEAR) &&
               !((op == hpm_pkg::REQ_ACK || op == hpm_pkg::REQ_NACK) && pid >= live_cnt);
   endtask

   // Event receiver: random stalls, and one long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            stall = quiet_rx ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      int k;
      int done;
      bit counted;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = hpm_pkg::REQ_SEND;
      req_proc_id = 7'd0;
      req_now_ms = 32'd0;
      csr_we = 1'b0;
      csr_index = hpm_pkg::CSR_PROCS_IN_USE;
      csr_wdata = 32'd0;
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
      hold_req = 1'b0;
      wall_ms = 32'd0;
      live_cnt = NUM_PROC;
      issued = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed opening under the reset register values.
      for (k = 0; k < NUM_PROC; k++) push_req(hpm_pkg::REQ_SEND, 7'd0, 32'd0);
      push_req(hpm_pkg::REQ_SEND, 7'd0, 32'd0);           // every process busy
      push_req(hpm_pkg::REQ_ACK, 7'd3, 32'd0);
      push_req(hpm_pkg::REQ_ACK, 7'd3, 32'd0);            // ack of a free process
      push_req(hpm_pkg::REQ_NACK, 7'd3, 32'd0);           // nack of a free process
      push_req(hpm_pkg::REQ_ACK, 7'd100, 32'd0);          // beyond the active count
      push_req(hpm_pkg::REQ_NACK, 7'd127, 32'hFFFF_FFFF);
      push_req(hpm_pkg::REQ_NACK, 7'd0, 32'd0);
      push_req(hpm_pkg::REQ_SEND, 7'd0, 32'd0);           // reuses the freed process
      push_req(hpm_pkg::REQ_TICK, 7'd0, 32'd10);          // deadlines hit exactly
      push_req(hpm_pkg::REQ_TICK, 7'd0, 32'h7FFF_FFFF);
      push_req(hpm_pkg::REQ_NACK, 7'd0, 32'd0);
      push_req(hpm_pkg::REQ_NACK, 7'd0, 32'd0);           // retry limit reached
      push_req(hpm_pkg::REQ_CLEAR, 7'd0, 32'd0);
      push_req(REQ_UNUSED_LO, 7'h7F, 32'hFFFF_FFFF);
      push_req(REQ_UNUSED_HI, 7'h55, 32'hAAAA_AAAA);
      push_req(hpm_pkg::REQ_TICK, 7'd0, 32'd3);           // older than the time mark
      push_req(hpm_pkg::REQ_SEND, 7'd0, 32'd0);
      wall_ms = 32'h7FFF_FFFF;

      for (k = 0; k < NUM_SETTINGS; k++) begin
         drain();
         if (k > 0) apply_setting(k);
         if (k == 0) hold_req = 1'b1;
         if (k == NUM_SETTINGS - 1) wall_ms = 32'hFFFF_FFF0;
         done = 0;
         while (done < ITEMS_PER_SETTING) begin
            if (issued % 16 == 0) begin
               quiet_tx = ($urandom_range(0, 3) == 0);
               quiet_rx = ($urandom_range(0, 3) == 0);
            end
            random_item(k == NUM_SETTINGS - 1, counted);
            if (counted) done++;
            if (counted && done == ITEMS_PER_SETTING / 2 && k == 3) drain();
         end
      end
      drain();

      $display("Ran %0d request items under %0d register settings, with a long output stall.",
               issued, NUM_SETTINGS);
      $display("Scored %0d event items, %0d of them retransmissions and %0d drops.",
               checked_count, resend_count, drop_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_harq_tx_process_manager_core: PASS");
      end else begin
         $display("tb_harq_tx_process_manager_core: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/hpm_pkg.sv
design/hpm_ram.sv
design/hpm_datapath.sv
design/hpm_ctrl.sv
design/harq_tx_process_manager_core.sv
dv/harq_tx_event_checker.sv
dv/tb_harq_tx_process_manager_core.sv
